/* rtl/binary_grid_automaton_smoother_defines.svh */
// assertion macros for the grid smoother
`ifndef BINARY_GRID_AUTOMATON_SMOOTHER_DEFINES_SVH
`define BINARY_GRID_AUTOMATON_SMOOTHER_DEFINES_SVH

`ifndef SYNTHESIS
`define BGAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgas assertion failed");
`define BGAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgas assertion failed");
`else
`define BGAS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BGAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/bgas_pkg.sv */
package bgas_pkg;

    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 64;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SMOOTH = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [7:0] PASS_COUNT_RST = 8'd10;
    localparam logic [3:0] NBR_THRESH     = 4'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] row;
        logic [5:0] col;
        logic       cell_in;
    } bgas_in_t;

    typedef struct packed {
        logic cell_out;
        logic smooth_done;
    } bgas_out_t;

    typedef struct packed {
        logic clear;
        logic acc_en;
        logic is_centre;
    } bgas_acc_ctl_t;

endpackage

/* rtl/bgas_grid_mem.sv */
module bgas_grid_mem
    import bgas_pkg::*;
#(
    parameter int DEPTH = GRID_ROWS_DEF * GRID_COLS_DEF,
    parameter int AW    = $clog2(GRID_ROWS_DEF * GRID_COLS_DEF)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bgas_nbr_unit.sv */
module bgas_nbr_unit
    import bgas_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bgas_acc_ctl_t ctl,
    input  logic          tap_bit,
    output logic          new_val
);

    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic       centre_reg;
    logic       centre_next;

    always_comb
    begin
        count_next  = count_reg;
        centre_next = centre_reg;
        if (ctl.clear)
        begin
            count_next = 4'd0;
        end
        else if (ctl.acc_en)
        begin
            if (ctl.is_centre)
            begin
                centre_next = tap_bit;
            end
            else
            begin
                count_next = count_reg + {3'd0, tap_bit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 4'd0;
            centre_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            centre_reg <= centre_next;
        end
    end

    // 4/5 rule: above four sets, below four clears, four keeps
    assign new_val = (count_reg > NBR_THRESH) ? 1'b1 :
                     (count_reg < NBR_THRESH) ? 1'b0 : centre_reg;

endmodule

/* rtl/binary_grid_automaton_smoother.sv */
// channel   | ports                         | beat taken when
// ----------+-------------------------------+------------------------------
// command   | start, busy, cmd              | start high and busy low
// result    | result_strobe, result         | result_strobe high (one cycle)
// config    | cfg_we, cfg_wdata             | cfg_we high
//
// a write leaves busy low; a read shows its result
// the cycle after the command, with busy high in that cycle.
// a smooth makes pass_count passes, each interior cell read through its nine
// taps and each border cell cleared, then one done cycle; the single memory
// read port reads one cell a cycle. reset is asynchronous and clears control
// state only; the grid is undefined until written. results cannot be stalled.
`include "binary_grid_automaton_smoother_defines.svh"

module binary_grid_automaton_smoother
    import bgas_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  bgas_in_t   cmd,
    output logic       result_strobe,
    output bgas_out_t  result,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CELL = 3'd2;
    localparam logic [2:0] S_TAP  = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    dr_reg, dr_next;
    logic [1:0]    dc_reg, dc_next;
    logic [7:0]    pass_reg, pass_next;
    logic [7:0]    pass_count_reg;
    logic          inside_reg, inside_next;
    logic          tap_vld_reg;
    logic          tap_ctr_reg;

    logic          accept;
    logic          cmd_inside;
    logic [AW-1:0] cmd_addr;
    logic [RW:0]   tap_row;
    logic [CW:0]   tap_col;
    logic [AW-1:0] tap_addr;
    logic [AW-1:0] cell_addr;
    logic          border;
    logic          last_col;
    logic          last_row;
    logic          last_pass;

    logic          mem_we;
    logic [AW-1:0] mem_wr_addr;
    logic          mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic          mem_rd_data;

    bgas_acc_ctl_t acc_ctl;
    logic          new_val;

    assign accept     = start && !busy;
    assign cmd_inside = (32'(cmd.row) < GRID_ROWS) && (32'(cmd.col) < GRID_COLS);
    assign cmd_addr   = AW'(32'(cmd.row) * GRID_COLS + 32'(cmd.col));

    assign tap_row   = {1'b0, row_reg} + (RW+1)'(dr_reg) - (RW+1)'(1);
    assign tap_col   = {1'b0, col_reg} + (CW+1)'(dc_reg) - (CW+1)'(1);
    assign tap_addr  = AW'(32'(tap_row) * GRID_COLS + 32'(tap_col));
    assign cell_addr = AW'(32'(row_reg) * GRID_COLS + 32'(col_reg));

    assign last_row  = (row_reg == RW'(GRID_ROWS - 1));
    assign last_col  = (col_reg == CW'(GRID_COLS - 1));
    assign border    = (row_reg == '0) || (col_reg == '0) || last_row || last_col;
    assign last_pass = (pass_reg == pass_count_reg - 8'd1);

    // pass count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_count_reg <= PASS_COUNT_RST;
        end
        else if (cfg_we)
        begin
            pass_count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        dr_next     = dr_reg;
        dc_next     = dc_reg;
        pass_next   = pass_reg;
        inside_next = inside_reg;
        mem_we      = 1'b0;
        mem_wr_addr = cell_addr;
        mem_wr_data = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = tap_addr;
        acc_ctl     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.kind)
                        KIND_WRITE:
                        begin
                            mem_we      = cmd_inside;
                            mem_wr_addr = cmd_addr;
                            mem_wr_data = cmd.cell_in;
                        end
                        KIND_READ:
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = cmd_addr;
                            inside_next = cmd_inside;
                            state_next  = S_READ;
                        end
                        KIND_SMOOTH:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            pass_next  = 8'd0;
                            state_next = (pass_count_reg == 8'd0) ? S_DONE : S_CELL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_CELL:
            begin
                if (!border)
                begin
                    acc_ctl.clear = 1'b1;
                    dr_next       = 2'd0;
                    dc_next       = 2'd0;
                    state_next    = S_TAP;
                end
            end
            S_TAP:
            begin
                mem_rd_en = 1'b1;
                if (dc_reg == 2'd2)
                begin
                    dc_next = 2'd0;
                    dr_next = dr_reg + 2'd1;
                    if (dr_reg == 2'd2)
                    begin
                        state_next = S_LAST;
                    end
                end
                else
                begin
                    dc_next = dc_reg + 2'd1;
                end
            end
            S_LAST:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                state_next = S_CELL;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // write back and step to the next cell
        if ((state_reg == S_CELL && border) || state_reg == S_WB)
        begin
            mem_we      = 1'b1;
            mem_wr_addr = cell_addr;
            mem_wr_data = (state_reg == S_WB) ? new_val : 1'b0;
            state_next  = S_CELL;
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next = '0;
                    if (last_pass)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pass_next = pass_reg + 8'd1;
                    end
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end

        acc_ctl.acc_en    = tap_vld_reg;
        acc_ctl.is_centre = tap_ctr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            dr_reg      <= 2'd0;
            dc_reg      <= 2'd0;
            pass_reg    <= 8'd0;
            inside_reg  <= 1'b0;
            tap_vld_reg <= 1'b0;
            tap_ctr_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            dr_reg      <= dr_next;
            dc_reg      <= dc_next;
            pass_reg    <= pass_next;
            inside_reg  <= inside_next;
            tap_vld_reg <= (state_reg == S_TAP);
            tap_ctr_reg <= (state_reg == S_TAP) && (dr_reg == 2'd1) && (dc_reg == 2'd1);
        end
    end

    bgas_grid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bgas_nbr_unit u_nbr_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (acc_ctl),
        .tap_bit (mem_rd_data),
        .new_val (new_val)
    );

    assign busy               = (state_reg != S_IDLE);
    assign result_strobe      = (state_reg == S_READ) || (state_reg == S_DONE);
    assign result.cell_out    = (state_reg == S_READ) && inside_reg && mem_rd_data;
    assign result.smooth_done = (state_reg == S_DONE);

    `BGAS_ASSERT_SAME(a_strobe_busy, clk, rst_n, result_strobe, busy)
    `BGAS_ASSERT_NEXT(a_single_beat, clk, rst_n, result_strobe, !result_strobe && !busy)
    `BGAS_ASSERT_SAME(a_done_no_cell, clk, rst_n, result.smooth_done, !result.cell_out)
    `BGAS_ASSERT_NEXT(a_write_quiet, clk, rst_n,
        accept && cmd.kind == KIND_WRITE, !busy && !result_strobe)
    `BGAS_ASSERT_NEXT(a_read_answers, clk, rst_n,
        accept && cmd.kind == KIND_READ, result_strobe && !result.smooth_done)

endmodule

/* bench/tb_binary_grid_automaton_smoother.sv */
`timescale 1ns / 1ps

module tb_binary_grid_automaton_smoother;
    import bgas_pkg::*;

    localparam logic [1:0] KIND_UNUSED        = 2'd3;
    localparam logic [7:0] PASSES_AFTER_RESET = 8'd10;
    localparam int         ROWS               = GRID_ROWS_DEF;
    localparam int         COLS               = GRID_COLS_DEF;
    localparam int         PHASE_ITEMS        = 110;
    localparam int         PRINT_CAP          = 200;

    typedef enum logic {STEP_CMD, STEP_CFG} step_op_t;

    typedef struct {
        step_op_t   op;
        bgas_in_t   c;
        logic [7:0] passes;
        bit         fixed;
        bgas_out_t  want;
    } step_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    bgas_in_t   cmd;
    logic       result_strobe;
    bgas_out_t  result;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    bit         grid_model [0:ROWS-1][0:COLS-1];
    logic [7:0] model_passes;
    bgas_out_t  pending_results[$];
    bgas_out_t  oldest;
    step_t      directed_steps[$];
    int         mismatch_count = 0;
    int         idle_pct = 0;

    logic [7:0] phase_passes [4] = '{8'd255, 8'd2, 8'd1, 8'd0};
    int         phase_idle   [4] = '{30, 77, 0, 0};
    int         phase_smooths[4] = '{0, 2, 3, 6};

    binary_grid_automaton_smoother dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_strobe(result_strobe),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // one in-place pass, row-major, already visited neighbours hold new values
    function automatic void smooth_grid_once();
        int n;
        for (int r = 0; r < ROWS; r++)
            for (int k = 0; k < COLS; k++)
            begin
                if (r == 0 || k == 0 || r == ROWS - 1 || k == COLS - 1)
                    grid_model[r][k] = 1'b0;
                else
                begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (dr != 0 || dc != 0)
                                n += grid_model[r + dr][k + dc];
                    if (n > NBR_THRESH)
                        grid_model[r][k] = 1'b1;
                    else if (n < NBR_THRESH)
                        grid_model[r][k] = 1'b0;
                end
            end
    endfunction

    function automatic void predict_command(input bgas_in_t c, output bit has_result,
                                            output bgas_out_t r);
        has_result = 1'b0;
        r          = '0;
        case (c.kind)
            KIND_WRITE:
                grid_model[c.row][c.col] = c.cell_in;
            KIND_SMOOTH:
            begin
                for (int p = 0; p < model_passes; p++)
                    smooth_grid_once();
                r.smooth_done = 1'b1;
                has_result    = 1'b1;
            end
            KIND_READ:
            begin
                r.cell_out = grid_model[c.row][c.col];
                has_result = 1'b1;
            end
            default:
                has_result = 1'b0;
        endcase
    endfunction

    function automatic void add_step(input step_op_t op, input logic [1:0] kind, input int r,
                                     input int k, input bit v, input int passes,
                                     input bit fixed, input bit want_cell, input bit want_done);
        step_t s;
        s.op               = op;
        s.c.kind           = kind;
        s.c.row            = 6'(r);
        s.c.col            = 6'(k);
        s.c.cell_in        = v;
        s.passes           = 8'(passes);
        s.fixed            = fixed;
        s.want.cell_out    = want_cell;
        s.want.smooth_done = want_done;
        directed_steps.push_back(s);
    endfunction

    // entered and left at a falling edge; start stays high for a following beat
    task automatic send_command(input bgas_in_t c, input bit fixed, input bgas_out_t want);
        bit        has_result;
        bgas_out_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        cmd   = c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_command(c, has_result, predicted);
        if (has_result)
            pending_results.push_back(fixed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_passes(input logic [7:0] v);
        drain();
        while (busy)
            @(negedge clk);
        // a trailing write gives no result, so let it settle
        repeat (3) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we       = 1'b0;
        model_passes = v;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing pending");
            else
            begin
                oldest = pending_results.pop_front();
                if (result.cell_out !== oldest.cell_out)
                    report_mismatch($sformatf("cell_out got %b want %b",
                                              result.cell_out, oldest.cell_out));
                if (result.smooth_done !== oldest.smooth_done)
                    report_mismatch($sformatf("smooth_done got %b want %b",
                                              result.smooth_done, oldest.smooth_done));
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        bgas_in_t    c;
        bgas_out_t   no_fixed;
        int          counted;
        int          budget;
        int unsigned pick;
        bit          held_off;
        logic [5:0]  last_row;
        logic [5:0]  last_col;

        no_fixed     = '0;
        held_off     = 1'b0;
        last_row     = '0;
        last_col     = '0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        model_passes = PASSES_AFTER_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every cell loaded before any read or smooth
        idle_pct = 30;
        for (int r = 0; r < ROWS; r++)
            for (int k = 0; k < COLS; k++)
            begin
                c.kind    = KIND_WRITE;
                c.row     = 6'(r);
                c.col     = 6'(k);
                c.cell_in = ($urandom_range(0, 99) < 45);
                send_command(c, 1'b0, no_fixed);
            end

        add_step(STEP_CMD, KIND_WRITE,   0,  0,  1, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_READ,    0,  0,  0, 0, 1, 1, 0);
        add_step(STEP_CMD, KIND_WRITE,  63, 63,  1, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_READ,   63, 63,  0, 0, 1, 1, 0);
        add_step(STEP_CMD, KIND_WRITE,   0, 63,  0, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_READ,    0, 63,  0, 0, 1, 0, 0);
        add_step(STEP_CMD, KIND_WRITE,  63,  0,  1, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_UNUSED, 63, 63,  1, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_UNUSED,  0,  0,  0, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_READ,   63,  0,  0, 0, 1, 1, 0);
        add_step(STEP_CMD, KIND_WRITE,  31, 42,  1, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_READ,   31, 42,  0, 0, 0, 0, 0);
        // smooth at the pass count left by reset
        add_step(STEP_CMD, KIND_SMOOTH,  0,  0,  0, 0, 1, 0, 1);
        add_step(STEP_CMD, KIND_READ,    0,  0,  0, 0, 1, 0, 0);
        add_step(STEP_CMD, KIND_READ,   63, 63,  0, 0, 1, 0, 0);
        add_step(STEP_CMD, KIND_READ,   32, 21,  0, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_READ,    1,  1,  0, 0, 0, 0, 0);
        // zero passes leave the grid alone
        add_step(STEP_CFG, KIND_WRITE,   0,  0,  0, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_WRITE,  62, 62,  1, 0, 0, 0, 0);
        add_step(STEP_CMD, KIND_SMOOTH, 17, 45,  1, 0, 1, 0, 1);
        add_step(STEP_CMD, KIND_READ,   62, 62,  0, 0, 1, 1, 0);
        add_step(STEP_CFG, KIND_WRITE,   0,  0,  0, 1, 0, 0, 0);
        add_step(STEP_CMD, KIND_SMOOTH,  0,  0,  0, 0, 1, 0, 1);
        add_step(STEP_CMD, KIND_READ,    0, 31,  0, 0, 1, 0, 0);
        add_step(STEP_CMD, KIND_READ,   30, 30,  0, 0, 0, 0, 0);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].op == STEP_CFG)
                set_passes(directed_steps[i].passes);
            else
                send_command(directed_steps[i].c, directed_steps[i].fixed,
                             directed_steps[i].want);
        end

        // random phases; smooth count kept low since each pass walks the whole grid
        for (int p = 0; p < 4; p++)
        begin
            set_passes(phase_passes[p]);
            idle_pct = phase_idle[p];
            budget   = phase_smooths[p];
            counted  = 0;
            while (counted < PHASE_ITEMS)
            begin
                if (p == 2 && counted == PHASE_ITEMS / 2 && !held_off)
                begin
                    drain();
                    held_off = 1'b1;
                end
                c.row     = 6'($urandom_range(0, ROWS - 1));
                c.col     = 6'($urandom_range(0, COLS - 1));
                c.cell_in = 1'($urandom_range(0, 1));
                pick      = $urandom_range(0, 99);
                if (budget > 0 && ($urandom_range(0, 39) == 0 || counted == PHASE_ITEMS - 1))
                begin
                    c.kind = KIND_SMOOTH;
                    budget--;
                end
                else if (pick < 6)
                    c.kind = KIND_UNUSED;
                else if (pick < 55)
                begin
                    c.kind   = KIND_WRITE;
                    last_row = c.row;
                    last_col = c.col;
                end
                else
                begin
                    c.kind = KIND_READ;
                    if (pick < 75)
                    begin
                        c.row = last_row;
                        c.col = last_col;
                    end
                end
                send_command(c, 1'b0, no_fixed);
                if (c.kind != KIND_UNUSED)
                    counted++;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
